// File: rtl/core/rsec_pkg.sv
// ----------------------------------------------------------------------------
// rsec_pkg
// Shared types, constants and a GF(256) multiply helper for the Reed-Solomon EC encoder.
// ----------------------------------------------------------------------------
package rsec_pkg;

    localparam int         MAX_EC_DEF   = 30;
    localparam int         MIN_EC       = 2;
    localparam int         EC_COUNT_W   = 5;
    localparam logic [4:0] EC_COUNT_RST = 5'd10;
    localparam logic [8:0] FIELD_POLY   = 9'h11D;
    localparam logic [7:0] GF_ONE       = 8'h01;
    localparam logic [7:0] GF_ALPHA     = 8'h02;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_data;
    } data_word_t;

    typedef struct packed {
        logic [7:0] ec_byte;
        logic       last_ec;
    } ec_word_t;

    typedef enum logic [1:0] {
        GEN_INIT,
        GEN_BUILD,
        GEN_READY
    } gen_state_t;

    // shift-and-add multiply, reduced by the field polynomial
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] x;
        logic [7:0] r;
        logic       carry;
        x = a;
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                r = r ^ x;
            end
            carry = x[7];
            x     = {x[6:0], 1'b0};
            if (carry)
            begin
                x = x ^ FIELD_POLY[7:0];
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/core/reed_solomon_ec_encoder_unit.sv
// ----------------------------------------------------------------------------
// reed_solomon_ec_encoder_unit
// Systematic RS encoder over GF(256): LFSR remainder per data word, EC words
// streamed out highest degree first after the last data word of a block.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            word
//  data      in         data_valid/stall     data_byte, last_data
//  ec        out        ec_valid/stall       ec_byte, last_ec
//  cfg       in         cfg_we               ec_count (5 bits)
//
// One data word per cycle unless stalled; the remainder updates in the accepting cycle.
// EC words leave one per cycle unless stalled, from a separate output bank, so
// the next block streams in while the previous one drains; a last word waits
// while EC words of the previous block are pending, unless the final one leaves that cycle.
// After reset, and after an ec_count write once any open block has closed, the
// generator is rebuilt for degree n (n = clamped ec_count, MIN_EC to MAX_EC);
// data_stall is high then. A block in progress keeps the degree it started with.
module reed_solomon_ec_encoder_unit #(
    parameter int MAX_EC = rsec_pkg::MAX_EC_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rsec_pkg::EC_COUNT_W-1:0]     cfg_wdata,
    input  logic                                data_valid,
    output logic                                data_stall,
    input  rsec_pkg::data_word_t                data_word,
    output logic                                ec_valid,
    input  logic                                ec_stall,
    output rsec_pkg::ec_word_t                  ec_word
);
    import rsec_pkg::*;

    localparam int CW = $clog2(MAX_EC + 1);
    localparam int IW = $clog2(MAX_EC);

    logic [EC_COUNT_W-1:0] ec_count_reg;
    gen_state_t            gen_state_reg, gen_state_next;
    logic [CW-1:0]         deg_reg, deg_next, deg_cfg, deg_m1;
    logic [CW-1:0]         step_reg, step_next;
    logic [7:0]            alpha_reg, alpha_next;
    logic [7:0]            coef_reg [MAX_EC+1];
    logic [7:0]            coef_next [MAX_EC+1];

    logic [7:0]            rem_reg  [MAX_EC];
    logic [7:0]            rem_next [MAX_EC];
    logic [7:0]            rem_lfsr [MAX_EC];
    logic [7:0]            osr_reg  [MAX_EC];
    logic [7:0]            osr_next [MAX_EC];
    logic [CW-1:0]         ocnt_reg, ocnt_next, ocnt_m1;
    logic [7:0]            fb;
    logic                  in_acc, out_pop, osr_free;
    logic                  blk_open_reg, blk_open_next;
    logic                  cfg_pend_reg, cfg_pend_next, rebuild_req;

    // clamp of the configured degree
    always_comb
    begin
        if (ec_count_reg < EC_COUNT_W'(MIN_EC))
        begin
            deg_cfg = CW'(MIN_EC);
        end
        else if (32'(ec_count_reg) > MAX_EC)
        begin
            deg_cfg = CW'(MAX_EC);
        end
        else
        begin
            deg_cfg = CW'(ec_count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ec_count_reg <= EC_COUNT_RST;
        end
        else if (cfg_we)
        begin
            ec_count_reg <= cfg_wdata;
        end
    end

    // generator build: one multiply by (x + alpha^i) per cycle, coef index = power of x
    always_comb
    begin
        gen_state_next = gen_state_reg;
        deg_next       = deg_reg;
        step_next      = step_reg;
        alpha_next     = alpha_reg;
        coef_next      = coef_reg;
        unique case (gen_state_reg)
            GEN_INIT:
            begin
                deg_next   = deg_cfg;
                step_next  = '0;
                alpha_next = GF_ONE;
                for (int k = 0; k <= MAX_EC; k++)
                begin
                    coef_next[k] = (k == 0) ? GF_ONE : 8'h00;
                end
                gen_state_next = GEN_BUILD;
            end
            GEN_BUILD:
            begin
                coef_next[0] = gf_mul(alpha_reg, coef_reg[0]);
                for (int k = 1; k <= MAX_EC; k++)
                begin
                    coef_next[k] = coef_reg[k-1] ^ gf_mul(alpha_reg, coef_reg[k]);
                end
                alpha_next = gf_mul(alpha_reg, GF_ALPHA);
                step_next  = step_reg + CW'(1);
                if (step_reg == deg_reg - CW'(1))
                begin
                    gen_state_next = GEN_READY;
                end
            end
            GEN_READY:
            begin
                gen_state_next = GEN_READY;
            end
            default:
            begin
                gen_state_next = GEN_INIT;
            end
        endcase
        // a write during a block takes effect once that block has closed
        if (rebuild_req && !blk_open_next)
        begin
            gen_state_next = GEN_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_state_reg <= GEN_INIT;
            deg_reg       <= CW'(MIN_EC);
            step_reg      <= '0;
            blk_open_reg  <= 1'b0;
            cfg_pend_reg  <= 1'b0;
        end
        else
        begin
            gen_state_reg <= gen_state_next;
            deg_reg       <= deg_next;
            step_reg      <= step_next;
            blk_open_reg  <= blk_open_next;
            cfg_pend_reg  <= cfg_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        alpha_reg <= alpha_next;
        coef_reg  <= coef_next;
    end

    // remainder LFSR, rem_reg[p] holds the x^p term
    assign osr_free   = (ocnt_reg == '0) || ((ocnt_reg == CW'(1)) && !ec_stall);
    assign data_stall = (gen_state_reg != GEN_READY) || (data_word.last_data && !osr_free);
    assign in_acc     = data_valid && !data_stall;
    assign out_pop    = ec_valid && !ec_stall;
    assign deg_m1     = deg_reg - CW'(1);
    assign fb         = data_word.data_byte ^ rem_reg[deg_m1[IW-1:0]];

    assign rebuild_req   = cfg_we || cfg_pend_reg;
    assign blk_open_next = in_acc ? !data_word.last_data : blk_open_reg;
    assign cfg_pend_next = rebuild_req && blk_open_next;

    always_comb
    begin
        rem_lfsr[0] = gf_mul(fb, coef_reg[0]);
        for (int p = 1; p < MAX_EC; p++)
        begin
            rem_lfsr[p] = rem_reg[p-1] ^ gf_mul(fb, coef_reg[p]);
        end
    end

    always_comb
    begin
        rem_next  = rem_reg;
        osr_next  = osr_reg;
        ocnt_next = ocnt_reg;
        if (out_pop)
        begin
            ocnt_next = ocnt_reg - CW'(1);
        end
        if (in_acc)
        begin
            if (data_word.last_data)
            begin
                rem_next  = '{default: 8'h00};
                osr_next  = rem_lfsr;
                ocnt_next = deg_reg;
            end
            else
            begin
                rem_next = rem_lfsr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '{default: 8'h00};
            ocnt_reg <= '0;
        end
        else
        begin
            rem_reg  <= rem_next;
            ocnt_reg <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        osr_reg <= osr_next;
    end

    // drain from the top term down
    assign ocnt_m1         = ocnt_reg - CW'(1);
    assign ec_valid        = (ocnt_reg != '0);
    assign ec_word.ec_byte = osr_reg[ocnt_m1[IW-1:0]];
    assign ec_word.last_ec = (ocnt_reg == CW'(1));

endmodule

// File: rtl/core/rsec_checker.sv
// ----------------------------------------------------------------------------
// rsec_checker
// Port-level checks on the Reed-Solomon EC encoder, bound to the encoder unit.
// ----------------------------------------------------------------------------
module rsec_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             data_valid,
    input logic                             data_stall,
    input rsec_pkg::data_word_t             data_word,
    input logic                             ec_valid,
    input logic                             ec_stall,
    input rsec_pkg::ec_word_t               ec_word
);
    import rsec_pkg::*;

    // a stalled EC word holds
    a_ec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ec_valid && ec_stall |=> ec_valid && $stable(ec_word))
        else $error("stalled ec word changed");

    // generator is still being built right after reset
    a_rst_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> data_stall)
        else $error("data taken before generator ready");

    // a closed block always yields EC words
    a_last_out: assert property (@(posedge clk) disable iff (!rst_n)
        data_valid && !data_stall && data_word.last_data |=> ec_valid)
        else $error("no ec words after last data word");

    // no gap inside a block's EC burst
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        ec_valid && !ec_stall && !ec_word.last_ec |=> ec_valid)
        else $error("ec burst ended without last flag");

endmodule

bind reed_solomon_ec_encoder_unit rsec_checker u_rsec_checker (.*);
